[hw/rtl/hmap_pkg.sv]
// Shared types, codes and fixed field widths of the hash map engine.
`default_nettype none

package hmap_pkg;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Stream word widths, padded to whole bytes
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;

    // Default sizing
    localparam int DEF_BUCKET_COUNT    = 256;
    localparam int DEF_WAYS_PER_BUCKET = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_GET    = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_CLEAR  = 2'd3
    } hmap_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DUP  = 2'd1,
        STATUS_MISS = 2'd2,
        STATUS_FULL = 2'd3
    } hmap_status_t;

    typedef enum logic [2:0] {
        S_RESET_SWEEP,
        S_IDLE,
        S_LOOKUP,
        S_CLEAR_SWEEP,
        S_CLEAR_DONE
    } hmap_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // latch input word, read its bucket
        logic execute;   // commit the command and load the result register
        logic sweep_wr;  // clear one bucket row, advance sweep counter
    } hmap_ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_is_clear;  // command on the input port is a clear
        logic sweep_last;   // sweep counter sits on the last bucket
        logic out_free;     // result register can take a new word
    } hmap_dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/hmap_ctrl.sv]
// Command sequencer of the hash map engine.
`default_nettype none

module hmap_ctrl
    import hmap_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire hmap_dp_status_t status,
    output hmap_ctrl_cmd_t       cmd
);

    hmap_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RESET_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            S_RESET_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.in_is_clear ? S_CLEAR_SWEEP : S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (status.out_free) begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_CLEAR_SWEEP: begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last) begin
                    state_next = S_CLEAR_DONE;
                end
            end
            S_CLEAR_DONE: begin
                if (status.out_free) begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_RESET_SWEEP;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/hmap_datapath.sv]
// Bucket memory, way compare, entry counter and result register.
`default_nettype none

module hmap_datapath
    import hmap_pkg::*;
#(
    parameter int BUCKET_COUNT    = DEF_BUCKET_COUNT,
    parameter int WAYS_PER_BUCKET = DEF_WAYS_PER_BUCKET
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    input  wire hmap_ctrl_cmd_t      cmd,
    output hmap_dp_status_t          status
);

    localparam int IDX_W      = $clog2(BUCKET_COUNT);
    localparam int WAYS       = WAYS_PER_BUCKET;
    localparam int TOTAL_WAYS = BUCKET_COUNT * WAYS_PER_BUCKET;
    localparam int CNT_MIN_W  = $clog2(TOTAL_WAYS + 1);
    localparam int CNT_W      = (CNT_MIN_W > COUNT_W) ? CNT_MIN_W : COUNT_W;
    localparam logic [IDX_W-1:0] BUCKET_MASK = IDX_W'(BUCKET_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(TOTAL_WAYS);

    // Input word fields
    hmap_cmd_t           in_cmd;
    logic [KEY_W-1:0]    in_key;
    logic [VALUE_W-1:0]  in_value;
    logic [IDX_W-1:0]    rd_addr;

    assign in_cmd   = hmap_cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_key   = s_tdata[CMD_W +: KEY_W];
    assign in_value = s_tdata[CMD_W+KEY_W +: VALUE_W];
    // Identity hash: low key bits pick the bucket
    assign rd_addr  = in_key[IDX_W-1:0] & BUCKET_MASK;

    // Bucket memories
    logic [WAYS-1:0]              valid_mem [BUCKET_COUNT];
    logic [WAYS-1:0][KEY_W-1:0]   key_mem   [BUCKET_COUNT];
    logic [WAYS-1:0][VALUE_W-1:0] value_mem [BUCKET_COUNT];

    logic [WAYS-1:0]              rd_valid_reg;
    logic [WAYS-1:0][KEY_W-1:0]   rd_key_reg;
    logic [WAYS-1:0][VALUE_W-1:0] rd_value_reg;

    // Latched command
    hmap_cmd_t          cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]   bucket_reg;

    // Control state
    logic [IDX_W-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    // Result register
    hmap_status_t       out_status_reg;
    logic [VALUE_W-1:0] out_read_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // Lookup results
    logic [WAYS-1:0]              hit_vec;
    logic [WAYS-1:0]              free_vec;
    logic [WAYS-1:0]              free_first;
    logic                         hit_any;
    logic                         bucket_full;
    logic [VALUE_W-1:0]           hit_value;
    logic [WAYS-1:0]              new_valid;
    logic [WAYS-1:0][KEY_W-1:0]   new_keys;
    logic [WAYS-1:0][VALUE_W-1:0] new_values;
    hmap_status_t                 exec_status;
    logic [VALUE_W-1:0]           exec_read;
    logic                         valid_we;
    logic                         kv_we;
    logic [IDX_W-1:0]             wr_addr;
    logic [WAYS-1:0]              wr_valid;

    // Parallel compare over the ways of the bucket
    always_comb begin
        hit_value = '0;
        new_keys   = rd_key_reg;
        new_values = rd_value_reg;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = rd_valid_reg[w] && (rd_key_reg[w] == key_reg);
            if (hit_vec[w]) begin
                hit_value = hit_value | rd_value_reg[w];
            end
        end
        free_vec    = ~rd_valid_reg;
        // lowest free way: isolate lowest set bit
        free_first  = free_vec & (~free_vec + WAYS'(1));
        hit_any     = |hit_vec;
        bucket_full = ~|free_vec;
        for (int w = 0; w < WAYS; w++) begin
            if (free_first[w]) begin
                new_keys[w]   = key_reg;
                new_values[w] = value_reg;
            end
        end
    end

    // Command outcome
    always_comb begin
        exec_status = STATUS_OK;
        exec_read   = '0;
        new_valid   = rd_valid_reg;
        count_next  = count_reg;
        valid_we    = 1'b0;
        kv_we       = 1'b0;
        case (cmd_reg)
            CMD_INSERT: begin
                if (hit_any) begin
                    exec_status = STATUS_DUP;
                end else if (bucket_full) begin
                    exec_status = STATUS_FULL;
                end else begin
                    new_valid  = rd_valid_reg | free_first;
                    count_next = count_reg + CNT_W'(1);
                    valid_we   = cmd.execute;
                    kv_we      = cmd.execute;
                end
            end
            CMD_GET: begin
                if (hit_any) begin
                    exec_read = hit_value;
                end else begin
                    exec_status = STATUS_MISS;
                end
            end
            CMD_ERASE: begin
                if (hit_any) begin
                    new_valid  = rd_valid_reg & ~hit_vec;
                    count_next = count_reg - CNT_W'(1);
                    valid_we   = cmd.execute;
                end else begin
                    exec_status = STATUS_MISS;
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                exec_status = STATUS_OK;
            end
        endcase
    end

    // Write port: sweep rows or write back the latched bucket
    assign wr_addr = cmd.sweep_wr ? sweep_reg : bucket_reg;
    assign wr_valid = cmd.sweep_wr ? '0 : new_valid;

    always_ff @(posedge aclk) begin
        if (cmd.sweep_wr || valid_we) begin
            valid_mem[wr_addr] <= wr_valid;
        end
        if (kv_we) begin
            key_mem[bucket_reg]   <= new_keys;
            value_mem[bucket_reg] <= new_values;
        end
        if (cmd.accept) begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_key_reg   <= key_mem[rd_addr];
            rd_value_reg <= value_mem[rd_addr];
        end
    end

    // Input latch
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg    <= in_cmd;
            key_reg    <= in_key;
            value_reg  <= in_value;
            bucket_reg <= rd_addr;
        end
    end

    // Sweep counter and result handshake
    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.sweep_wr) begin
            sweep_next = (sweep_reg == BUCKET_MASK) ? '0 : sweep_reg + IDX_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (cmd.execute) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            if (cmd.execute) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            out_status_reg <= exec_status;
            out_read_reg   <= exec_read;
            out_count_reg  <= count_next[COUNT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    // m_tdata: status, read_value, entry_count, zero pad
    assign m_tdata  = {{(M_DATA_W - STATUS_W - VALUE_W - COUNT_W){1'b0}},
                       out_count_reg, out_read_reg, out_status_reg};

    assign status.in_is_clear = (in_cmd == CMD_CLEAR);
    assign status.sweep_last  = (sweep_reg == BUCKET_MASK);
    assign status.out_free    = !out_valid_reg || m_tready;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("entry count exceeds table size");

    a_exec_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> out_valid_reg)
        else $error("result not presented after execute");

    a_no_exec_over_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while still waiting");

    a_sweep_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_wr |-> (!cmd.execute && !cmd.accept))
        else $error("sweep overlaps a command");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && cmd_reg == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries counted");
`endif

endmodule

`default_nettype wire

[hw/rtl/hash_map_engine.sv]
// Top level of the hash map engine: sequencer plus datapath.
`default_nettype none

// Key-value table driven by one command word per transfer: insert, get, erase
// or clear. Each command returns one result word. The key's low bits select
// one of BUCKET_COUNT buckets of WAYS_PER_BUCKET ways each; inserts take the
// lowest free way and are refused if the key is present or the bucket is full.
// Insert, get and erase each run a bucket memory read, then a parallel compare
// and write back; s_tready stays low until the result is loaded, so no new
// command is taken while one is in the lookup. A clear sweeps every
// bucket row, one a cycle, before the next command is taken. After reset the
// same sweep runs with s_tready low. A new command is taken while the
// previous result waits.
module hash_map_engine
    import hmap_pkg::*;
#(
    parameter int BUCKET_COUNT    = DEF_BUCKET_COUNT,
    parameter int WAYS_PER_BUCKET = DEF_WAYS_PER_BUCKET
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // cmd[1:0], key[33:2], value[65:34]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // status[1:0], read_value[33:2],
                                                // entry_count[44:34]
);

    hmap_ctrl_cmd_t  ctrl_cmd;
    hmap_dp_status_t dp_status;

    hmap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    hmap_datapath #(
        .BUCKET_COUNT    (BUCKET_COUNT),
        .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (ctrl_cmd),
        .status   (dp_status)
    );

endmodule

`default_nettype wire

[dv/hash_map_engine_chk.sv]
`timescale 1ns / 100ps
// Checker for the hash map engine: predicts each result word and compares it.
module hash_map_engine_chk
    import hmap_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata,
    output int                       mismatch_count,
    output int                       outstanding
);

    localparam int BUCKETS = DEF_BUCKET_COUNT;
    localparam int WAYS    = DEF_WAYS_PER_BUCKET;
    localparam int SLOTS   = BUCKETS * WAYS;

    typedef struct packed {
        hmap_status_t         status;
        logic [VALUE_W-1:0]   read_value;
        logic [COUNT_W-1:0]   entry_count;
    } hmap_result_t;

    // Shadow copy of the table
    logic                slot_used  [SLOTS];
    logic [KEY_W-1:0]    slot_key   [SLOTS];
    logic [VALUE_W-1:0]  slot_value [SLOTS];
    logic [COUNT_W-1:0]  entries;

    hmap_result_t pending_results[$];

    // Apply one command to the shadow table and return the result it gives
    function automatic hmap_result_t table_apply(hmap_cmd_t cmd, logic [KEY_W-1:0] key,
                                                 logic [VALUE_W-1:0] value);
        int           base;
        int           hit;
        int           free_slot;
        hmap_result_t res;
        base = int'((key & KEY_W'(BUCKETS - 1)) % KEY_W'(BUCKETS)) * WAYS;
        hit = -1;
        free_slot = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (slot_used[base + w] && slot_key[base + w] == key && hit < 0)
                hit = base + w;
            // lowest free way wins
            if (!slot_used[base + w] && free_slot < 0)
                free_slot = base + w;
        end
        res.status = STATUS_OK;
        res.read_value = '0;
        case (cmd)
            CMD_INSERT: begin
                // duplicate check takes precedence over a full bucket
                if (hit >= 0) begin
                    res.status = STATUS_DUP;
                end else if (free_slot < 0) begin
                    res.status = STATUS_FULL;
                end else begin
                    slot_used[free_slot]  = 1'b1;
                    slot_key[free_slot]   = key;
                    slot_value[free_slot] = value;
                    entries = entries + 1'b1;
                end
            end
            CMD_GET: begin
                if (hit >= 0) res.read_value = slot_value[hit];
                else res.status = STATUS_MISS;
            end
            CMD_ERASE: begin
                if (hit >= 0) begin
                    slot_used[hit] = 1'b0;
                    entries = entries - 1'b1;
                end else begin
                    res.status = STATUS_MISS;
                end
            end
            default: begin
                foreach (slot_used[i]) slot_used[i] = 1'b0;
                entries = '0;
            end
        endcase
        res.entry_count = entries;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Compare result words first, then predict from the accepted command word
    always @(posedge aclk) begin
        hmap_result_t want;
        if (!aresetn) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            entries = '0;
            pending_results.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", '0,
                                    m_tdata[STATUS_W +: VALUE_W]);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[STATUS_W-1:0] != want.status)
                        report_mismatch("status", 32'(want.status),
                                        32'(m_tdata[STATUS_W-1:0]));
                    if (m_tdata[STATUS_W +: VALUE_W] != want.read_value)
                        report_mismatch("read_value", want.read_value,
                                        m_tdata[STATUS_W +: VALUE_W]);
                    if (m_tdata[STATUS_W+VALUE_W +: COUNT_W] != want.entry_count)
                        report_mismatch("entry_count", 32'(want.entry_count),
                                        32'(m_tdata[STATUS_W+VALUE_W +: COUNT_W]));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(table_apply(hmap_cmd_t'(s_tdata[CMD_W-1:0]),
                                                      s_tdata[CMD_W +: KEY_W],
                                                      s_tdata[CMD_W+KEY_W +: VALUE_W]));
            outstanding <= pending_results.size();
        end
    end

endmodule

[dv/hash_map_engine_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the hash map engine: clock, reset, command stimulus and verdict.
module hash_map_engine_tb;
    import hmap_pkg::*;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int mismatch_count;
    int outstanding;

    bit               quiet_phase = 1'b0;   // no idling on either side
    int               rx_stall    = 0;
    logic [KEY_W-1:0] key_pool [64];        // recently inserted keys, for hits
    logic [7:0]       hot_buckets [4];      // buckets that get crowded

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    hash_map_engine #(
        .BUCKET_COUNT    (DEF_BUCKET_COUNT),
        .WAYS_PER_BUCKET (DEF_WAYS_PER_BUCKET)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hash_map_engine_chk u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 99) < 20) begin
            rx_stall <= gap_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one command word and hold it until taken; tvalid stays up
    // when the next word follows straight away
    task automatic send_word(hmap_cmd_t cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
        int gap;
        s_tdata  <= {{(S_DATA_W - CMD_W - KEY_W - VALUE_W){1'b0}}, value, key, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        gap = 0;
        if (!quiet_phase && $urandom_range(0, 99) < 30) gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every result word is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // One random command: mostly keys that collide or hit, some pure noise
    task automatic random_command();
        int               pick;
        hmap_cmd_t        cmd;
        logic [23:0]      upper;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 42) cmd = CMD_INSERT;
        else if (pick < 72) cmd = CMD_GET;
        else if (pick < 97) cmd = CMD_ERASE;
        else cmd = CMD_CLEAR;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            key = key_pool[$urandom_range(0, 63)];
        end else if (pick < 85) begin
            // few distinct upper parts so the hot buckets overflow
            if ($urandom_range(0, 9) < 7) upper = 24'($urandom_range(0, 7));
            else upper = 24'($urandom);
            key = {upper, hot_buckets[$urandom_range(0, 3)]};
        end else begin
            key = $urandom;
        end
        if (cmd == CMD_INSERT) key_pool[$urandom_range(0, 63)] = key;
        send_word(cmd, key, $urandom);
    endtask

    // Stimulus and verdict
    initial begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, key extremes, full bucket, duplicates, clear
        send_word(CMD_CLEAR,  32'h0000_0000, 32'h0000_0000);
        send_word(CMD_GET,    32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_ERASE,  32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_word(CMD_GET,    32'h0000_0000, 32'h0000_0000);
        send_word(CMD_GET,    32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_INSERT, 32'h0000_0005, 32'h0000_0011);
        send_word(CMD_INSERT, 32'h0000_0105, 32'h0000_0022);
        send_word(CMD_INSERT, 32'h0000_0205, 32'h0000_0033);
        send_word(CMD_INSERT, 32'h0000_0305, 32'h0000_0044);
        send_word(CMD_INSERT, 32'h0000_0405, 32'h0000_0055);
        send_word(CMD_INSERT, 32'h0000_0105, 32'h0000_0066);
        send_word(CMD_ERASE,  32'h0000_0205, 32'h0000_0000);
        send_word(CMD_INSERT, 32'h0000_0405, 32'hA5A5_A5A5);
        send_word(CMD_GET,    32'h0000_0405, 32'h0000_0000);
        send_word(CMD_GET,    32'h0000_0205, 32'h0000_0000);
        send_word(CMD_ERASE,  32'h0000_0000, 32'h0000_0000);
        send_word(CMD_GET,    32'h0000_0000, 32'h0000_0000);
        send_word(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_word(CMD_GET,    32'hAAAA_AAAA, 32'h0000_0000);
        send_word(CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_GET,    32'hFFFF_FFFF, 32'h0000_0000);
        wait_for_results();

        // random segments, some of them without any idling
        for (int segment = 0; segment < 13; segment++) begin
            quiet_phase <= (segment % 4 == 1);
            foreach (hot_buckets[i]) hot_buckets[i] = 8'($urandom);
            for (int n = 0; n < 100; n++) random_command();
            if (segment == 6 || $urandom_range(0, 2) == 0) wait_for_results();
        end

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
